### rtl/core/rwc_pkg.sv
// Shared types and constants for the rolling window checksum block.
package rwc_pkg;

   localparam logic [30:0] PRIME_M = 31'h7fffffff;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_SUM_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTIPLIER  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_OFFSET = 2'd2;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_ROLL   = 1'b1;

   // Multiplier operand selection.
   typedef enum logic [1:0] {
      MSEL_SUM   = 2'd0,   // running sum times multiplier
      MSEL_POW   = 2'd1,   // power times old byte
      MSEL_FILL  = 2'd2    // previous power times multiplier
   } msel_type;

   typedef struct packed {
      logic     load;       // capture request beat
      logic     mul_go;     // issue multiply
      msel_type msel;
      logic     acc_clear;  // start accumulator with product
      logic     acc_add;    // add product into accumulator
      logic     finish;     // reduce, write sum, present result
      logic     mode0;      // finish using mode 0 path
      logic     pow_rd;     // read power store at k
      logic     fill_wr;    // write fill product to store
      logic     fill_seed;  // write seed entry 0
   } rwc_cmd_type;

   typedef struct packed {
      logic need_fill;  // powers_filled <= k
      logic empty;      // powers_filled == 0
   } rwc_status_type;

   // Fold a 64-bit value down to a residue below PRIME_M. Since 2^31 is one
   // modulo PRIME_M, bits 63..62 carry a weight of one as well.
   function automatic logic [30:0] fold_m(input logic [63:0] x);
      logic [33:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = {3'b0, x[30:0]} + {3'b0, x[61:31]} + {32'b0, x[63:62]};
      b = {1'b0, a[30:0]} + {29'b0, a[33:31]};
      c = {1'b0, b[30:0]} + {31'b0, b[31]};
      fold_m = (c[30:0] == PRIME_M) ? 31'd0 : c[30:0];
   endfunction

endpackage

### rtl/core/rwc_stream_if.sv
// Valid/ready stream interface with a parameterized payload.
interface rwc_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/rwc_ctrl.sv
// Sequencing state machine for the rolling window checksum.
module rwc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_fire,
   input  logic                    req_op,
   input  logic                    mode1,
   input  logic                    rsp_busy,
   input  rwc_pkg::rwc_status_type status,
   output logic                    req_ready,
   output rwc_pkg::rwc_cmd_type    cmd
);
   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_SEED  = 8'b00000010,
      S_FILLM = 8'b00000100,
      S_FILLW = 8'b00001000,
      S_MUL1  = 8'b00010000,
      S_MUL2  = 8'b00100000,
      S_ACC   = 8'b01000000,
      S_FIN   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic      roll_ff, roll_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         roll_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         roll_ff  <= roll_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_busy;

   always_comb begin
      state_in = state_ff;
      roll_in  = roll_ff;
      cmd = '0;
      cmd.msel = rwc_pkg::MSEL_SUM;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               roll_in  = (req_op == rwc_pkg::OP_ROLL);
               if (!mode1) state_in = S_FIN;
               else if (req_op == rwc_pkg::OP_ROLL) state_in = S_SEED;
               else state_in = S_MUL1;
            end
         end
         S_SEED: begin
            if (status.empty) cmd.fill_seed = 1'b1;
            state_in = S_FILLM;
         end
         S_FILLM: begin
            if (status.need_fill) begin
               cmd.mul_go = 1'b1;
               cmd.msel   = rwc_pkg::MSEL_FILL;
               state_in   = S_FILLW;
            end else begin
               cmd.pow_rd = 1'b1;
               state_in   = S_MUL1;
            end
         end
         S_FILLW: begin
            cmd.fill_wr = 1'b1;
            state_in    = S_FILLM;
         end
         S_MUL1: begin
            cmd.mul_go = 1'b1;
            cmd.msel   = rwc_pkg::MSEL_SUM;
            state_in   = roll_ff ? S_MUL2 : S_ACC;
         end
         S_MUL2: begin
            cmd.mul_go    = 1'b1;
            cmd.msel      = rwc_pkg::MSEL_POW;
            cmd.acc_clear = 1'b1;
            state_in      = S_ACC;
         end
         S_ACC: begin
            if (roll_ff) cmd.acc_add = 1'b1;
            else cmd.acc_clear = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            cmd.mode0  = !mode1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

### rtl/core/rwc_datapath.sv
// Datapath: sums, shared modular multiplier, power store and result register.
module rwc_datapath #(
   parameter int unsigned MAX_WINDOW = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rwc_pkg::rwc_cmd_type    cmd,
   output rwc_pkg::rwc_status_type status,
   input  logic                    cfg_wr,
   input  logic [30:0]             multiplier,
   input  logic [7:0]              byte_offset,
   input  logic                    req_op,
   input  logic                    req_start,
   input  logic [7:0]              req_new,
   input  logic [7:0]              req_old,
   input  logic                    req_has_new,
   input  logic [12:0]             req_k,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [31:0]             rsp_checksum
);
   localparam int unsigned DEPTH = MAX_WINDOW + 1;
   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [31:0] sum_ff;
   logic        op_ff, start_ff, has_new_ff;
   logic [7:0]  new_ff, old_ff;
   logic [12:0] k_ff;
   logic [AW-1:0] ksat_ff;
   logic [CW-1:0] filled_ff, filled_in;
   logic [30:0] mem [DEPTH];
   logic [30:0] pow_ff, prev_ff;
   logic [62:0] prod_ff;
   logic [63:0] acc_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic [30:0] ma, mb;

   // Saturated window length for the power lookup.
   logic [AW-1:0] ksat_in;
   always_comb begin
      if ({19'b0, req_k} > 32'(MAX_WINDOW)) ksat_in = AW'(MAX_WINDOW);
      else ksat_in = AW'(req_k);
   end

   assign status.need_fill = ({{(32-CW){1'b0}}, filled_ff} <= {{(32-AW){1'b0}}, ksat_ff});
   assign status.empty     = (filled_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op; start_ff <= req_start; new_ff <= req_new;
         old_ff <= req_old; has_new_ff <= req_has_new; k_ff <= req_k;
         ksat_ff <= ksat_in;
      end
   end

   // Power store and fill count.
   always_comb begin
      filled_in = filled_ff;
      if (cmd.fill_seed) filled_in = CW'(1);
      else if (cmd.fill_wr) filled_in = filled_ff + CW'(1);
      if (cfg_wr) filled_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) filled_ff <= '0;
      else filled_ff <= filled_in;
   end

   // The newest power is forwarded straight into prev_ff so that the next
   // fill multiply sees it without a read-after-write delay.
   always_ff @(posedge clock) begin
      if (cmd.fill_seed) mem[0] <= rwc_pkg::PRIME_M - 31'd1;
      if (cmd.fill_wr) mem[filled_ff[AW-1:0]] <= rwc_pkg::fold_m({1'b0, prod_ff});
      if (cmd.fill_seed) prev_ff <= rwc_pkg::PRIME_M - 31'd1;
      else if (cmd.fill_wr) prev_ff <= rwc_pkg::fold_m({1'b0, prod_ff});
      else prev_ff <= mem[filled_ff[AW-1:0] - AW'(1)];
      if (cmd.pow_rd) pow_ff <= mem[ksat_ff];
   end

   // Shared 31x31 multiplier with registered product.
   always_comb begin
      case (cmd.msel)
         rwc_pkg::MSEL_SUM:  begin ma = start_ff && !op_ff ? 31'd0 : 31'(sum_ff); mb = multiplier; end
         rwc_pkg::MSEL_POW:  begin ma = pow_ff;  mb = {23'b0, old_ff}; end
         rwc_pkg::MSEL_FILL: begin ma = prev_ff; mb = multiplier; end
         default:            begin ma = '0;      mb = '0; end
      endcase
   end

   // The stored sum may hold bit 31 after a mode switch; add its weight.
   logic [61:0] hi_term;
   logic [61:0] prod_lo;
   assign hi_term = ((cmd.msel == rwc_pkg::MSEL_SUM) && sum_ff[31] && !(start_ff && !op_ff))
                  ? {multiplier, 31'b0} : '0;
   assign prod_lo = ma * mb;

   always_ff @(posedge clock) begin
      if (cmd.mul_go) prod_ff <= {1'b0, prod_lo} + {1'b0, hi_term};
      if (cmd.acc_clear) acc_ff <= {1'b0, prod_ff};
      else if (cmd.acc_add) acc_ff <= acc_ff + {1'b0, prod_ff};
   end

   // Mode 0 arithmetic modulo 2^16.
   logic [15:0] v_old, v_new, s1, s2, s1r, s2r;
   logic [31:0] sum_in;
   logic [63:0] acc_fin;
   always_comb begin
      v_old = {{8{old_ff[7]}}, old_ff} + {8'b0, byte_offset};
      v_new = {{8{new_ff[7]}}, new_ff} + {8'b0, byte_offset};
      s1 = sum_ff[15:0];
      s2 = sum_ff[31:16];
      if (op_ff == rwc_pkg::OP_APPEND) begin
         if (start_ff) begin s1 = '0; s2 = '0; end
         s1r = s1 + v_new;
         s2r = s2 + s1r;
      end else begin
         s1r = s1 - v_old;
         s2r = s2 - 16'(k_ff * v_old);
         if (has_new_ff) begin
            s1r = s1r + v_new;
            s2r = s2r + s1r;
         end
      end
      acc_fin = acc_ff + {56'b0, (op_ff == rwc_pkg::OP_APPEND || has_new_ff) ? new_ff : 8'd0};
      if (cmd.mode0) sum_in = {s2r, s1r};
      else sum_in = {1'b0, rwc_pkg::fold_m(acc_fin)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            sum_ff <= sum_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) rsp_data_ff <= sum_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_checksum = rsp_data_ff;
endmodule

### rtl/core/rolling_window_checksum.sv
// Rolling window checksum: Adler-style sums or polynomial hash mod 2^31-1.
// Mode 0 goes from accept to finish and the result beat; mode 1 append first runs
// the sum multiply and accumulate; mode 1 roll seeds and fills missing powers (fill
// is amortized), then runs both multiplies. A new beat waits for the result to leave.
// The power store fills on demand, through the one shared 31x31 multiplier.
// Synchronous active-high reset clears the sum, registers and power fill count.
module rolling_window_checksum #(
   parameter int unsigned MAX_WINDOW = 4096
) (
   input  logic clock,
   input  logic reset,
   rwc_stream_if.sink   req,
   rwc_stream_if.source rsp,
   input  logic                              csr_we,
   input  logic [rwc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rwc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   // Configuration registers. Any valid write invalidates the power store.
   logic        sum_mode_ff;
   logic [30:0] multiplier_ff;
   logic [7:0]  byte_offset_ff;
   logic        cfg_hit;

   always_comb begin
      case (csr_index)
         rwc_pkg::CSR_SUM_MODE, rwc_pkg::CSR_MULTIPLIER,
         rwc_pkg::CSR_BYTE_OFFSET: cfg_hit = csr_we;
         default:                  cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_mode_ff    <= 1'b0;
         multiplier_ff  <= '0;
         byte_offset_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rwc_pkg::CSR_SUM_MODE:    sum_mode_ff    <= csr_wdata[0];
            rwc_pkg::CSR_MULTIPLIER:  multiplier_ff  <= csr_wdata[30:0];
            rwc_pkg::CSR_BYTE_OFFSET: byte_offset_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   rwc_pkg::rwc_cmd_type    cmd;
   rwc_pkg::rwc_status_type status;
   logic req_ready;

   assign req.ready = req_ready;

   // A new request beat is taken only when the result register is empty.
   rwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req.valid && req_ready),
      .req_op    (req.data.op),
      .mode1     (sum_mode_ff),
      .rsp_busy  (rsp.valid),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   rwc_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cfg_wr       (cfg_hit),
      .multiplier   (multiplier_ff),
      .byte_offset  (byte_offset_ff),
      .req_op       (req.data.op),
      .req_start    (req.data.start_req),
      .req_new      (req.data.new_byte),
      .req_old      (req.data.old_byte),
      .req_has_new  (req.data.has_new),
      .req_k        (req.data.window_len),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .rsp_checksum (rsp.data.checksum)
   );
endmodule

### rtl/core/rwc_checker.sv
// Port-level assertions for the rolling window checksum, bound to the top level.
module rwc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_checksum
);
   a_no_accept_with_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_checksum))
      else $error("result dropped or changed");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result after reset");
   a_accept_no_same_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("back to back accept");
endmodule

bind rolling_window_checksum rwc_checker u_rwc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_checksum (rsp.data.checksum)
);
